// ===== hdl/lcm_pkg.sv =====
// Shared types and constants for the literal cell matcher.
// Used by the input and configuration channel interfaces and all modules of the block; no dependencies.
package lcm_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int BYTE_W            = 8;
  localparam int LIT_LEN_W         = 6;
  localparam int LIT_IDX_W         = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int WORD_W            = 64;
  localparam int WORD_BYTES        = WORD_W / BYTE_W;
  localparam int WORD_COUNT        = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int CNT_W             = 6;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_WORD_0  = 3'd0,
    REG_PATTERN_WORD_1  = 3'd1,
    REG_PATTERN_WORD_2  = 3'd2,
    REG_PATTERN_WORD_3  = 3'd3,
    REG_PATTERN_LENGTH  = 3'd4,
    REG_EXACT_MODE      = 3'd5,
    REG_PATTERN_PRESENT = 3'd6
  } lcm_reg_idx_t;

  // Query kinds
  localparam logic REQ_CELL = 1'b0;
  localparam logic REQ_SPAN = 1'b1;

  // Active configuration as seen by the match core
  typedef struct packed {
    logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] lit;
    logic [LIT_LEN_W-1:0]                     len;      // already clamped
    logic                                     exact;
    logic                                     present;
  } lcm_cfg_t;

  // One input item
  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] text_byte;
    logic              byte_valid;
    logic              last_byte;
  } lcm_item_t;

endpackage

// ===== hdl/lcm_in_if.sv =====
// Input channel of the literal cell matcher: one text byte item per handshake.
// Depends on lcm_pkg for field widths.
interface lcm_in_if;
  import lcm_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] text_byte;
  logic              byte_valid;
  logic              last_byte;

  modport source (output valid, output req_type, output text_byte, output byte_valid,
                  output last_byte, input ready);
  modport sink   (input valid, input req_type, input text_byte, input byte_valid,
                  input last_byte, output ready);
endinterface

// ===== hdl/lcm_out_if.sv =====
// Result channel of the literal cell matcher: one match item per cell or span.
// No package dependencies.
interface lcm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic query_kind;

  modport source (output valid, output matched, output query_kind, input ready);
  modport sink   (input valid, input matched, input query_kind, output ready);
endinterface

// ===== hdl/lcm_cfg_if.sv =====
// Configuration write channel of the literal cell matcher.
// Depends on lcm_pkg for index and data widths.
interface lcm_cfg_if;
  import lcm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lcm_cfg_regs.sv =====
// Configuration register file of the literal cell matcher.
// Depends on lcm_pkg and lcm_cfg_if; presents the literal and modes as lcm_cfg_t.
module lcm_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  lcm_cfg_if.sink           cfg_ch,
  output lcm_pkg::lcm_cfg_t cfg
);
  import lcm_pkg::*;

  logic [WORD_COUNT-1:0][WORD_W-1:0] word_r;
  logic [LIT_LEN_W-1:0]              len_r;
  logic                              exact_r;
  logic                              present_r;
  logic                              wr_en;

  // writes always accepted
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r    <= '0;
      len_r     <= '0;
      exact_r   <= 1'b0;
      present_r <= 1'b0;
    end else if (wr_en) begin
      case (cfg_ch.index)
        REG_PATTERN_WORD_0:  word_r[0] <= cfg_ch.data[WORD_W-1:0];
        REG_PATTERN_WORD_1:  word_r[1] <= cfg_ch.data[WORD_W-1:0];
        REG_PATTERN_WORD_2:  word_r[2] <= cfg_ch.data[WORD_W-1:0];
        REG_PATTERN_WORD_3:  word_r[3] <= cfg_ch.data[WORD_W-1:0];
        REG_PATTERN_LENGTH:  len_r     <= cfg_ch.data[LIT_LEN_W-1:0];
        REG_EXACT_MODE:      exact_r   <= cfg_ch.data[0];
        REG_PATTERN_PRESENT: present_r <= cfg_ch.data[0];
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

  // literal bytes, byte 0 of each word in its low bits
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_lit
    assign cfg.lit[i] = word_r[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_W +: BYTE_W];
  end

  // lengths above the literal capacity act as full length
  assign cfg.len     = (len_r > LIT_LEN_W'(MAX_PATTERN_BYTES)) ?
                       LIT_LEN_W'(MAX_PATTERN_BYTES) : len_r;
  assign cfg.exact   = exact_r;
  assign cfg.present = present_r;

endmodule

// ===== hdl/lcm_match_core.sv =====
// Per-cell match state and compare logic of the literal cell matcher.
// Depends on lcm_pkg. Keeps a prefix-match vector, byte count and flags per cell.
module lcm_match_core (
  input  logic               clk,
  input  logic               rst_n,
  input  lcm_pkg::lcm_cfg_t  cfg,
  input  logic               fire,
  input  lcm_pkg::lcm_item_t item,
  output logic               matched
);
  import lcm_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // prefix_r[k]: the newest k+1 bytes equal literal bytes 0..k
  logic [MAX_PATTERN_BYTES-1:0] prefix_r, prefix_nxt, byte_eq;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         found_r, found_nxt;
  logic                         exact_ok_r, exact_ok_nxt;
  logic [LIT_IDX_W-1:0]         hit_idx;
  logic                         hit;
  logic                         pos_bad;

  // one comparator per literal position
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cmp
    assign byte_eq[k] = (item.text_byte == cfg.lit[k]);
  end

  assign hit_idx = LIT_IDX_W'(cfg.len - LIT_LEN_W'(1));
  assign pos_bad = (cnt_r >= CNT_W'(cfg.len)) ||
                   (item.text_byte != cfg.lit[cnt_r[LIT_IDX_W-1:0]]);

  // state after this item's byte
  always_comb begin
    prefix_nxt   = prefix_r;
    cnt_nxt      = cnt_r;
    exact_ok_nxt = exact_ok_r;
    if (item.byte_valid) begin
      prefix_nxt   = {prefix_r[MAX_PATTERN_BYTES-2:0], 1'b1} & byte_eq;
      cnt_nxt      = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
      exact_ok_nxt = exact_ok_r & ~pos_bad;
    end
    hit       = item.byte_valid && (cfg.len != '0) && prefix_nxt[hit_idx];
    found_nxt = found_r | hit;
  end

  // result rules, using state that includes this item
  always_comb begin
    if (item.req_type == REQ_SPAN && !cfg.present) begin
      matched = 1'b1;
    end else if (cfg.len == '0 || cnt_nxt == '0) begin
      matched = 1'b0;
    end else if (item.req_type == REQ_CELL && cfg.exact) begin
      matched = (cnt_nxt == CNT_W'(cfg.len)) && exact_ok_nxt;
    end else begin
      matched = found_nxt;
    end
  end

  // per-cell state; the last item of a cell returns it to reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r   <= '0;
      cnt_r      <= '0;
      found_r    <= 1'b0;
      exact_ok_r <= 1'b1;
    end else if (fire) begin
      if (item.last_byte) begin
        prefix_r   <= '0;
        cnt_r      <= '0;
        found_r    <= 1'b0;
        exact_ok_r <= 1'b1;
      end else begin
        prefix_r   <= prefix_nxt;
        cnt_r      <= cnt_nxt;
        found_r    <= found_nxt;
        exact_ok_r <= exact_ok_nxt;
      end
    end
  end

endmodule

// ===== hdl/literal_cell_matcher.sv =====
// Top level of the literal cell matcher: input register, match core, result register.
// Depends on lcm_pkg, the three channel interfaces, lcm_cfg_regs and lcm_match_core.
//
// Streams the bytes of a cell or span, one item per clock, and returns one match item
// when the item flagged last_byte has been processed. The block takes a new item every
// cycle: each item is captured in the input register and compared against all literal
// positions in the next cycle by one comparator per literal byte; when a last item leaves
// the input register, its result item is loaded into the result register. The only stall
// is when a last item sits in the input register while the result register is still
// full and not being taken; items that end no cell pass through regardless.
// Configuration writes are always accepted and must be made while no cell is in progress.
module literal_cell_matcher (
  input  logic      clk,
  input  logic      rst_n,
  lcm_in_if.sink    in_ch,
  lcm_out_if.source out_ch,
  lcm_cfg_if.sink   cfg_ch
);
  import lcm_pkg::*;

  lcm_cfg_t  cfg;
  lcm_item_t s1_item_r, in_item;
  logic      s1_valid_r;
  logic      s1_fire;
  logic      core_matched;
  logic      out_valid_r, out_matched_r, out_kind_r;

  lcm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // input register
  assign in_item = '{req_type:   in_ch.req_type,
                     text_byte:  in_ch.text_byte,
                     byte_valid: in_ch.byte_valid,
                     last_byte:  in_ch.last_byte};

  assign s1_fire     = s1_valid_r &&
                       (!s1_item_r.last_byte || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= in_item;
    end
  end

  lcm_match_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fire    (s1_fire),
    .item    (s1_item_r),
    .matched (core_matched)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_item_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item_r.last_byte) begin
      out_matched_r <= core_matched;
      out_kind_r    <= s1_item_r.req_type;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.matched    = out_matched_r;
  assign out_ch.query_kind = out_kind_r;

  // a processed last item always leaves a result behind
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.last_byte) |=> out_valid_r)
    else $error("last item processed without result");

  // a new result only follows a processed last item
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_item_r.last_byte))
    else $error("result without a last item");

  // span query with no literal set answers one
  a_span_no_literal: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.last_byte && s1_item_r.req_type == REQ_SPAN && !cfg.present)
    |=> out_matched_r)
    else $error("span query without literal did not match");

  // cell query with empty literal never matches
  a_cell_empty_literal: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.last_byte && s1_item_r.req_type == REQ_CELL && cfg.len == '0)
    |=> !out_matched_r)
    else $error("cell query matched an empty literal");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for literal_cell_matcher: streams cells and spans, predicts
// each match item, and compares it with the block's output under random idling.
// Depends on lcm_pkg and the lcm_in_if, lcm_out_if and lcm_cfg_if channel interfaces.
module testbench;
  import lcm_pkg::*;

  typedef logic [BYTE_W-1:0] byte_q_t [$];

  typedef struct packed {
    logic matched;
    logic kind;
  } match_t;

  // Tracks the literal, the per-cell window and the match items still owed by the block
  class match_tracker;
    logic [WORD_W-1:0]    lit_word [WORD_COUNT];
    logic [LIT_LEN_W-1:0] lit_len_reg;
    logic                 exact_reg;
    logic                 present_reg;
    logic [BYTE_W-1:0]    window [MAX_PATTERN_BYTES];
    int unsigned          seen;
    bit                   found;
    bit                   exact_ok;
    match_t               pending[$];
    int unsigned          errors;

    function new();
      foreach (lit_word[i]) lit_word[i] = '0;
      lit_len_reg = '0;
      exact_reg   = 1'b0;
      present_reg = 1'b0;
      errors      = 0;
      clear_cell();
    endfunction

    function void clear_cell();
      foreach (window[i]) window[i] = '0;
      seen     = 0;
      found    = 1'b0;
      exact_ok = 1'b1;
    endfunction

    function logic [BYTE_W-1:0] lit_byte(int unsigned i);
      return lit_word[(i / WORD_BYTES) % WORD_COUNT][(i % WORD_BYTES)*BYTE_W +: BYTE_W];
    endfunction

    function void note_cfg(lcm_reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PATTERN_WORD_0:  lit_word[0] = data;
        REG_PATTERN_WORD_1:  lit_word[1] = data;
        REG_PATTERN_WORD_2:  lit_word[2] = data;
        REG_PATTERN_WORD_3:  lit_word[3] = data;
        REG_PATTERN_LENGTH:  lit_len_reg = data[LIT_LEN_W-1:0];
        REG_EXACT_MODE:      exact_reg = data[0];
        REG_PATTERN_PRESENT: present_reg = data[0];
        default: ;
      endcase
    endfunction

    // Advance the cell state by one item; a last item owes one match item
    function void note_item(lcm_item_t it);
      int unsigned len;
      bit          hit;
      match_t      m;
      len = (lit_len_reg > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : lit_len_reg;
      if (it.byte_valid) begin
        if (seen >= len || it.text_byte != lit_byte(seen % MAX_PATTERN_BYTES))
          exact_ok = 1'b0;
        for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = it.text_byte;
        if (seen < 63) seen++;
        if (len > 0 && seen >= len) begin
          hit = 1'b1;
          for (int i = 0; i < len; i++)
            if (window[len-1-i] != lit_byte(i)) hit = 1'b0;
          if (hit) found = 1'b1;
        end
      end
      if (!it.last_byte) return;
      m.kind = it.req_type;
      if (it.req_type == REQ_SPAN && !present_reg)
        m.matched = 1'b1;
      else if (len == 0 || seen == 0)
        m.matched = 1'b0;
      else if (it.req_type == REQ_CELL && exact_reg)
        m.matched = (seen == len) && exact_ok;
      else
        m.matched = found;
      pending.push_back(m);
      clear_cell();
    endfunction

    function void check_match(logic matched, logic kind);
      match_t m;
      if (pending.size() == 0) begin
        $display("%0t: unexpected match item: expected none, got matched=%0b kind=%0b",
                 $time, matched, kind);
        errors++;
        return;
      end
      m = pending.pop_front();
      if (matched !== m.matched) begin
        $display("%0t: matched mismatch: expected %0b, got %0b", $time, m.matched, matched);
        errors++;
      end
      if (kind !== m.kind) begin
        $display("%0t: query_kind mismatch: expected %0b, got %0b", $time, m.kind, kind);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lcm_in_if  in_ch();
  lcm_out_if out_ch();
  lcm_cfg_if cfg_ch();

  literal_cell_matcher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  match_tracker tracker = new();

  int               send_idle_pct;
  int               recv_stall_pct;
  int               items_sent;
  logic [BYTE_W-1:0] lit_bytes [MAX_PATTERN_BYTES];
  int               lit_n;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #400000;
    $display("literal_cell_matcher verification failed");
    $finish;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Observe handshakes on all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready)
        tracker.note_cfg(lcm_reg_idx_t'(cfg_ch.index), cfg_ch.data);
      if (out_ch.valid && out_ch.ready)
        tracker.check_match(out_ch.matched, out_ch.query_kind);
      if (in_ch.valid && in_ch.ready)
        tracker.note_item({in_ch.req_type, in_ch.text_byte, in_ch.byte_valid,
                           in_ch.last_byte});
    end
  end

  // One input item, with random idle cycles ahead of it
  task automatic put_item(logic req, logic [BYTE_W-1:0] b, logic bv, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.text_byte  <= b;
    in_ch.byte_valid <= bv;
    in_ch.last_byte  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // A whole cell; noise items carry no byte, a terminator ends the cell without a byte
  task automatic send_cell(byte_q_t text, logic req, bit terminate, int noise_pct,
                           int mix_pct);
    logic r;
    bit   fin;
    foreach (text[i]) begin
      while ($urandom_range(0, 99) < noise_pct) begin
        put_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
        items_sent++;
      end
      fin = (i == text.size() - 1) && !terminate;
      r = (!fin && $urandom_range(0, 99) < mix_pct) ? 1'($urandom_range(0, 1)) : req;
      put_item(r, text[i], 1'b1, fin);
    end
    if (terminate || text.size() == 0) begin
      put_item(req, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent++;
    end
    items_sent += text.size();
  endtask

  task automatic cfg_write(lcm_reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_config(logic [WORD_W-1:0] w [WORD_COUNT], logic [LIT_LEN_W-1:0] len,
                             logic ex, logic pres);
    cfg_write(REG_PATTERN_WORD_0, w[0]);
    cfg_write(REG_PATTERN_WORD_1, w[1]);
    cfg_write(REG_PATTERN_WORD_2, w[2]);
    cfg_write(REG_PATTERN_WORD_3, w[3]);
    cfg_write(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    cfg_write(REG_EXACT_MODE, CFG_DATA_W'(ex));
    cfg_write(REG_PATTERN_PRESENT, CFG_DATA_W'(pres));
    cfg_ch.valid <= 1'b0;
    // stimulus keeps its own copy of the literal for building hits
    for (int i = 0; i < MAX_PATTERN_BYTES; i++)
      lit_bytes[i] = w[i / WORD_BYTES][(i % WORD_BYTES)*BYTE_W +: BYTE_W];
    lit_n = (len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : len;
  endtask

  // Wait for every owed match item, then let the pipeline empty
  task automatic drain();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic byte_q_t text_of(string s);
    byte_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    return q;
  endfunction

  // Biased toward literal bytes so partial and overlapping hits are common
  function automatic logic [BYTE_W-1:0] pick_byte();
    if (lit_n > 0 && $urandom_range(0, 1))
      return lit_bytes[$urandom_range(0, lit_n - 1)];
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic byte_q_t random_text();
    byte_q_t t;
    int      kind;
    int      n;
    int      p;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // literal somewhere inside the cell
      n = $urandom_range(0, 5);
      repeat (n) t.push_back(pick_byte());
      for (int i = 0; i < lit_n; i++) t.push_back(lit_bytes[i]);
      n = $urandom_range(0, 5);
      repeat (n) t.push_back(pick_byte());
    end else if (kind < 55) begin
      for (int i = 0; i < lit_n; i++) t.push_back(lit_bytes[i]);
    end else if (kind < 65) begin
      // near miss: one bit flipped
      for (int i = 0; i < lit_n; i++) t.push_back(lit_bytes[i]);
      if (lit_n > 0) begin
        p = $urandom_range(0, lit_n - 1);
        t[p][$urandom_range(0, BYTE_W - 1)] ^= 1'b1;
      end
    end else if (kind < 72) begin
      for (int i = 0; i + 1 < lit_n; i++) t.push_back(lit_bytes[i]);
    end else if (kind < 77) begin
      for (int i = 0; i < lit_n; i++) t.push_back(lit_bytes[i]);
      t.push_back(pick_byte());
    end else if (kind < 87) begin
      n = $urandom_range(1, 10);
      repeat (n) t.push_back(BYTE_W'($urandom_range(0, 255)));
    end else if (kind < 92) begin
      // empty cell
    end else if (kind < 96) begin
      // long text, around the count saturation
      n = $urandom_range(58, 70);
      repeat (n) t.push_back(pick_byte());
      if ($urandom_range(0, 1))
        for (int i = 0; i < lit_n; i++) t.push_back(lit_bytes[i]);
    end else begin
      // repeated literal prefix in front of the literal
      n = (lit_n > 0) ? $urandom_range(0, lit_n - 1) : 0;
      for (int i = 0; i < n; i++) t.push_back(lit_bytes[i]);
      for (int i = 0; i < lit_n; i++) t.push_back(lit_bytes[i]);
    end
    return t;
  endfunction

  // Stimulus
  initial begin
    logic [WORD_W-1:0]    w [WORD_COUNT];
    logic [LIT_LEN_W-1:0] len_table [12];
    int                   start;

    len_table = '{6'd3, 6'd1, 6'd32, 6'd63, 6'd0, 6'd5, 6'd8, 6'd33, 6'd2, 6'd16,
                  6'd4, 6'd7};
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_CELL;
    in_ch.text_byte  = '0;
    in_ch.byte_valid = 1'b0;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_PATTERN_WORD_0;
    cfg_ch.data      = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    items_sent       = 0;
    lit_n            = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: literal "abc", substring mode
    w = '{64'h636261, 64'h0, 64'h0, 64'h0};
    load_config(w, 6'd3, 1'b0, 1'b1);
    send_cell(text_of("xabcz"), REQ_CELL, 1'b0, 0, 0);
    put_item(REQ_CELL, 8'h61, 1'b0, 1'b0);
    put_item(REQ_CELL, 8'hFF, 1'b0, 1'b1);
    send_cell(text_of("ab"), REQ_SPAN, 1'b1, 0, 0);
    // extreme bytes, request kind taken from the last item only
    put_item(REQ_SPAN, 8'h00, 1'b1, 1'b0);
    put_item(REQ_CELL, 8'hFF, 1'b1, 1'b1);
    items_sent += 4;
    in_ch.valid <= 1'b0;
    drain();

    // Directed: exact mode
    load_config(w, 6'd3, 1'b1, 1'b1);
    send_cell(text_of("abc"), REQ_CELL, 1'b0, 0, 0);
    send_cell(text_of("abcd"), REQ_CELL, 1'b0, 0, 0);
    send_cell(text_of("xabc"), REQ_SPAN, 1'b0, 0, 0);
    send_cell(text_of("abc"), REQ_CELL, 1'b1, 0, 0);
    in_ch.valid <= 1'b0;
    drain();

    // Random phases over literal lengths, modes and idling patterns
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      foreach (w[i]) begin
        if (ph == 4)      w[i] = '0;
        else if (ph == 6) w[i] = '1;
        else              w[i] = {$urandom, $urandom};
      end
      load_config(w, len_table[ph], 1'((ph >> 1) & 1), ((ph >> 2) & 1) == 0);
      start = items_sent;
      while (items_sent - start < 80)
        send_cell(random_text(), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                  8, 15);
      in_ch.valid <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    if (tracker.errors == 0)
      $display("literal_cell_matcher verification clean");
    else
      $display("literal_cell_matcher verification failed");
    $finish;
  end

endmodule
